/* hw/rtl/vau_pkg.sv */
package vau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OP_BITS       = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_MUL   = 3'd3,
        OP_DOT   = 3'd4,
        OP_CROSS = 3'd5,
        OP_NORM  = 3'd6
    } t_op;

endpackage

/* hw/rtl/vau_front.sv */
module vau_front #(
    parameter int WORD_BITS = vau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [vau_pkg::OP_BITS-1:0]  i_op,
    input  logic [WORD_BITS-1:0]         i_a [3],
    input  logic [WORD_BITS-1:0]         i_b [3],
    input  logic [WORD_BITS-1:0]         i_s,
    output logic                         o_vld,
    output logic [vau_pkg::OP_BITS-1:0]  o_op,
    output logic [WORD_BITS-1:0]         o_r [3],
    output logic [WORD_BITS-1:0]         o_dot,
    output logic                         o_sat,
    output logic [2*WORD_BITS-1:0]       o_sumsq
);
    import vau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int VW = 2 * WORD_BITS + 2;
    localparam logic signed [VW-1:0] HALF = {{(VW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    // round to nearest (ties up), then clamp; returns {sat, value}
    function automatic logic [W:0] rnd_sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        logic                 fits;
        logic [W-1:0]         res;
        t    = (v + HALF) >>> FRAC_BITS;
        fits = (&t[VW-1:W-1]) || !(|t[VW-1:W-1]);
        if (fits) begin
            res = t[W-1:0];
        end else if (t[VW-1]) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b0, {(W-1){1'b1}}};
        end
        return {!fits, res};
    endfunction

    // stage 0: input register
    logic               r0_vld;
    logic [OP_BITS-1:0] r0_op;
    logic [W-1:0]       r0_a [3];
    logic [W-1:0]       r0_b [3];
    logic [W-1:0]       r0_s;

    // stage 1: products
    logic                    r1_vld;
    logic [OP_BITS-1:0]      r1_op;
    logic [W-1:0]            r1_a [3];
    logic [W-1:0]            r1_b [3];
    logic signed [2*W-1:0]   r1_p [6];
    logic [W-1:0]            mul_l [6];
    logic [W-1:0]            mul_r [6];
    logic signed [2*W-1:0]   n_p [6];

    // stage 2: full-precision sums
    logic                    r2_vld;
    logic [OP_BITS-1:0]      r2_op;
    logic [W-1:0]            r2_a [3];
    logic signed [VW-1:0]    r2_v [3];
    logic signed [VW-1:0]    n_v [3];

    // stage 3: rounded and clamped
    logic                    r3_vld;
    logic [OP_BITS-1:0]      r3_op;
    logic [W-1:0]            r3_r [3];
    logic [W-1:0]            r3_dot;
    logic                    r3_sat;
    logic [2*W-1:0]          r3_sq;
    logic [W-1:0]            n_r [3];
    logic [W-1:0]            n_dot;
    logic                    n_sat;
    logic [2*W-1:0]          n_sq;
    logic [W:0]              rs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_l[i]   = r0_a[i];
            mul_r[i]   = r0_b[i];
            mul_l[i+3] = r0_a[i];
            mul_r[i+3] = r0_b[i];
        end
        unique case (r0_op)
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) mul_r[i] = r0_s;
            end
            OP_NORM: begin
                for (int i = 0; i < 3; i++) mul_r[i] = r0_a[i];
            end
            OP_CROSS: begin
                mul_l[0] = r0_a[1]; mul_r[0] = r0_b[2];
                mul_l[1] = r0_a[2]; mul_r[1] = r0_b[0];
                mul_l[2] = r0_a[0]; mul_r[2] = r0_b[1];
                mul_l[3] = r0_a[2]; mul_r[3] = r0_b[1];
                mul_l[4] = r0_a[0]; mul_r[4] = r0_b[2];
                mul_l[5] = r0_a[1]; mul_r[5] = r0_b[0];
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            n_p[k] = $signed(mul_l[k]) * $signed(mul_r[k]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n_v[i] = VW'(r1_p[i]);
        unique case (r1_op) inside
            OP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    n_v[i] = (VW'($signed(r1_a[i])) + VW'($signed(r1_b[i]))) <<< FRAC_BITS;
                end
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_v[i] = (VW'($signed(r1_a[i])) - VW'($signed(r1_b[i]))) <<< FRAC_BITS;
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) n_v[i] = VW'(r1_p[i]) - VW'(r1_p[i+3]);
            end
            OP_DOT, OP_NORM: begin
                n_v[0] = VW'(r1_p[0]) + VW'(r1_p[1]) + VW'(r1_p[2]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rs[i]  = rnd_sat(r2_v[i]);
            n_r[i] = '0;
        end
        n_dot = '0;
        n_sat = 1'b0;
        n_sq  = '0;
        unique case (r2_op) inside
            OP_ADD, OP_SUB, OP_SCALE, OP_MUL, OP_CROSS: begin
                for (int i = 0; i < 3; i++) n_r[i] = rs[i][W-1:0];
                n_sat = rs[0][W] | rs[1][W] | rs[2][W];
            end
            OP_DOT: begin
                n_dot = rs[0][W-1:0];
                n_sat = rs[0][W];
            end
            OP_NORM: begin
                // pass A on; the tail replaces it unless the magnitude is 0 or 1.0
                for (int i = 0; i < 3; i++) n_r[i] = r2_a[i];
                n_sq = r2_v[0][2*W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r0_op  <= i_op;
            r0_a   <= i_a;
            r0_b   <= i_b;
            r0_s   <= i_s;
            r1_op  <= r0_op;
            r1_a   <= r0_a;
            r1_b   <= r0_b;
            r1_p   <= n_p;
            r2_op  <= r1_op;
            r2_a   <= r1_a;
            r2_v   <= n_v;
            r3_op  <= r2_op;
            r3_r   <= n_r;
            r3_dot <= n_dot;
            r3_sat <= n_sat;
            r3_sq  <= n_sq;
        end
    end

    assign o_vld   = r3_vld;
    assign o_op    = r3_op;
    assign o_r     = r3_r;
    assign o_dot   = r3_dot;
    assign o_sat   = r3_sat;
    assign o_sumsq = r3_sq;

endmodule

/* hw/rtl/vau_sqrt.sv */
module vau_sqrt #(
    parameter int WORD_BITS = 32,
    parameter int SIDE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [2*WORD_BITS-1:0] i_rad,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_vld,
    output logic [WORD_BITS-1:0]   o_root,
    output logic [SIDE_BITS-1:0]   o_side
);
    localparam int W = WORD_BITS;

    // one root bit per stage, restoring method
    logic [W+1:0]         r_rem  [W];
    logic [W-1:0]         r_root [W];
    logic [2*W-1:0]       r_rad  [W];
    logic [SIDE_BITS-1:0] r_side [W];
    logic [W-1:0]         r_vld;

    logic [W+1:0]         n_rem  [W];
    logic [W-1:0]         n_root [W];
    logic [2*W-1:0]       n_rad  [W];

    always_comb begin
        logic [W+1:0]   p_rem;
        logic [W-1:0]   p_root;
        logic [2*W-1:0] p_rad;
        logic [W+1:0]   cur;
        logic [W+1:0]   trial;
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_rad  = i_rad;
            end else begin
                p_rem  = r_rem[k-1];
                p_root = r_root[k-1];
                p_rad  = r_rad[k-1];
            end
            cur   = {p_rem[W-1:0], p_rad[2*W-1 -: 2]};
            trial = {p_root, 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {p_root[W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {p_root[W-2:0], 1'b0};
            end
            n_rad[k] = {p_rad[2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W-2:0], i_vld};
        end
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side[0] <= i_side;
            for (int k = 1; k < W; k++) r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[W-1];
    assign o_root = r_root[W-1];
    assign o_side = r_side[W-1];

endmodule

/* hw/rtl/vau_div.sv */
module vau_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [WORD_BITS-1:0] i_num [3],
    input  logic [WORD_BITS-1:0] i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_vld,
    output logic [FRAC_BITS:0]   o_quo [3],
    output logic [SIDE_BITS-1:0] o_side
);
    localparam int W  = WORD_BITS;
    localparam int QB = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 1;

    // three lanes share the divisor; one quotient bit per stage
    logic [W-1:0]         r_rem  [NS][3];
    logic [QB-1:0]        r_quo  [NS][3];
    logic [W-1:0]         r_den  [NS];
    logic [SIDE_BITS-1:0] r_side [NS];
    logic [NS-1:0]        r_vld;

    logic [W-1:0]         n_rem  [NS][3];
    logic [QB-1:0]        n_quo  [NS][3];

    always_comb begin
        logic [W:0]    cur;
        logic [W-1:0]  den;
        logic [QB-1:0] pq;
        logic          bit_q;
        logic [W:0]    diff;
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    cur = {1'b0, i_num[l]};
                    den = i_den;
                    pq  = '0;
                end else begin
                    cur = {r_rem[k-1][l], 1'b0};
                    den = r_den[k-1];
                    pq  = r_quo[k-1][l];
                end
                diff  = cur - {1'b0, den};
                bit_q = cur >= {1'b0, den};
                n_rem[k][l] = bit_q ? diff[W-1:0] : cur[W-1:0];
                n_quo[k][l] = {pq[QB-2:0], bit_q};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
        if (i_en) begin
            r_rem     <= n_rem;
            r_quo     <= n_quo;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_quo[NS-1];
    assign o_side = r_side[NS-1];

endmodule

/* hw/rtl/vec3_arithmetic_unit.sv */
// Every operation takes the same path from input transaction to result; the default
// number format is Q16.16.
// Throughput: one transaction per cycle; the front pipeline, the square-root
// pipeline (one root bit per stage) and the divider (one quotient bit per stage) all
// advance together, and only a stalled output holds the whole pipe.
// Reset: synchronous, active low; clears the valid bits only, payload is not reset.
module vec3_arithmetic_unit #(
    parameter int WORD_BITS = vau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scalar
    input  logic [((7*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // operation
    input  logic [vau_pkg::OP_BITS-1:0]           s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // r_x, r_y, r_z, dot_value
    output logic [((4*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // saturated, passed_through
    output logic [1:0]                            m_axis_tuser
);
    import vau_pkg::*;

    localparam int W        = WORD_BITS;
    localparam int OUT_BITS = ((4*WORD_BITS+7)/8)*8;
    localparam int SQ_SIDE  = OP_BITS + 1 + 4*W;
    localparam int DV_SIDE  = SQ_SIDE + 1;
    localparam logic [W-1:0] FIX_ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic pipe_en;

    logic [W-1:0] in_a [3];
    logic [W-1:0] in_b [3];
    logic [W-1:0] in_s;

    logic               fr_vld;
    logic [OP_BITS-1:0] fr_op;
    logic [W-1:0]       fr_r [3];
    logic [W-1:0]       fr_dot;
    logic               fr_sat;
    logic [2*W-1:0]     fr_sq;

    logic               sq_vld;
    logic [W-1:0]       sq_root;
    logic [SQ_SIDE-1:0] sq_side;
    logic [OP_BITS-1:0] sq_op;
    logic               sq_pass;
    logic [W-1:0]       sq_mag [3];
    logic [W-1:0]       sq_c;

    logic               dv_vld;
    logic [FRAC_BITS:0] dv_quo [3];
    logic [DV_SIDE-1:0] dv_side;
    logic [OP_BITS-1:0] dv_op;
    logic               dv_pass;
    logic [W-1:0]       dv_c;
    logic [W-1:0]       dv_q;

    logic                r_out_vld;
    logic [OUT_BITS-1:0] r_out_data;
    logic [1:0]          r_out_user;
    logic [OUT_BITS-1:0] n_out_data;
    logic [1:0]          n_out_user;

    // advance everything unless a finished result is waiting
    assign pipe_en       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_a[i] = s_axis_tdata[i*W +: W];
            in_b[i] = s_axis_tdata[(i+3)*W +: W];
        end
        in_s = s_axis_tdata[6*W +: W];
    end

    vau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_s     (in_s),
        .o_vld   (fr_vld),
        .o_op    (fr_op),
        .o_r     (fr_r),
        .o_dot   (fr_dot),
        .o_sat   (fr_sat),
        .o_sumsq (fr_sq)
    );

    vau_sqrt #(
        .WORD_BITS (WORD_BITS),
        .SIDE_BITS (SQ_SIDE)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (fr_vld),
        .i_rad   (fr_sq),
        .i_side  ({fr_op, fr_sat, fr_dot, fr_r[2], fr_r[1], fr_r[0]}),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        sq_op   = sq_side[4*W+1 +: OP_BITS];
        sq_pass = (sq_op == OP_NORM) && ((sq_root == '0) || (sq_root == FIX_ONE));
        for (int i = 0; i < 3; i++) begin
            sq_c      = sq_side[i*W +: W];
            sq_mag[i] = sq_c[W-1] ? (~sq_c + {{(W-1){1'b0}}, 1'b1}) : sq_c;
        end
    end

    vau_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_BITS (DV_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (sq_vld),
        .i_num   (sq_mag),
        .i_den   (sq_root),
        .i_side  ({sq_pass, sq_side}),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        dv_op      = dv_side[4*W+1 +: OP_BITS];
        dv_pass    = dv_side[SQ_SIDE];
        n_out_data = '0;
        n_out_data[3*W +: W] = dv_side[3*W +: W];
        for (int i = 0; i < 3; i++) begin
            dv_c = dv_side[i*W +: W];
            dv_q = W'(dv_quo[i]);
            if ((dv_op == OP_NORM) && !dv_pass) begin
                n_out_data[i*W +: W] = dv_c[W-1] ? (~dv_q + {{(W-1){1'b0}}, 1'b1}) : dv_q;
            end else begin
                n_out_data[i*W +: W] = dv_c;
            end
        end
        n_out_user = {dv_pass, dv_side[4*W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_out_vld <= dv_vld;
        end
        if (pipe_en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

/* bench/tb_top.sv */
module tb_top;
    import vau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int LATENCY = WB + FB + 6;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] r_x;
        logic [31:0] r_y;
        logic [31:0] r_z;
        logic [31:0] dot_value;
        logic        saturated;
        logic        passed_through;
    } vec_result_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    vec_result_t expected_q[$];
    int          mismatch_count;
    int          idle_cycles;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_off_cycles;
    bit          timed_out;

    vec3_arithmetic_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round to nearest (ties up) a full-precision value, then clamp to the word.
    function automatic logic [31:0] round_clamp(input logic signed [127:0] v,
                                                inout logic sat);
        logic signed [127:0] t;
        t = (v + 128'sd32768) >>> FB;
        if (t > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (t < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return t[31:0];
    endfunction

    function automatic logic [31:0] clamp_sum(input logic signed [33:0] v, inout logic sat);
        if (v > 34'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -34'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 55; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_component(input logic signed [31:0] c,
                                                   input logic [63:0] m);
        logic [95:0] n;
        logic [95:0] q;
        n = c[31] ? 96'(-64'(c)) : 96'(c);
        q = (n << FB) / {32'd0, m};
        return c[31] ? 32'(-q) : q[31:0];
    endfunction

    function automatic vec_result_t vector_result(input logic [2:0] op,
                                                  input logic signed [31:0] a [3],
                                                  input logic signed [31:0] b [3],
                                                  input logic signed [31:0] s);
        vec_result_t         r;
        logic                sat;
        logic signed [127:0] acc;
        logic [127:0]        sq;
        logic [63:0]         m;
        logic [31:0]         rv [3];
        r = '0;
        sat = 1'b0;
        rv = '{default: '0};
        case (op)
            OP_ADD: for (int i = 0; i < 3; i++)
                rv[i] = clamp_sum(34'(a[i]) + 34'(b[i]), sat);
            OP_SUB: for (int i = 0; i < 3; i++)
                rv[i] = clamp_sum(34'(a[i]) - 34'(b[i]), sat);
            OP_SCALE: for (int i = 0; i < 3; i++)
                rv[i] = round_clamp(128'(a[i]) * 128'(s), sat);
            OP_MUL: for (int i = 0; i < 3; i++)
                rv[i] = round_clamp(128'(a[i]) * 128'(b[i]), sat);
            OP_DOT: begin
                acc = 128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1])
                    + 128'(a[2]) * 128'(b[2]);
                r.dot_value = round_clamp(acc, sat);
            end
            OP_CROSS: begin
                rv[0] = round_clamp(128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]), sat);
                rv[1] = round_clamp(128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]), sat);
                rv[2] = round_clamp(128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]), sat);
            end
            OP_NORM: begin
                sq = 128'(128'(a[0]) * 128'(a[0]) + 128'(a[1]) * 128'(a[1])
                    + 128'(a[2]) * 128'(a[2]));
                m = isqrt(sq);
                if (m == 0 || m == (64'd1 << FB)) begin
                    r.passed_through = 1'b1;
                    for (int i = 0; i < 3; i++) rv[i] = a[i];
                end else begin
                    for (int i = 0; i < 3; i++) rv[i] = unit_component(a[i], m);
                end
            end
            default: ;
        endcase
        r.r_x = rv[0];
        r.r_y = rv[1];
        r.r_z = rv[2];
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return 32'hffff0000;
            4: return 32'd0;
            5, 6: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(input logic [2:0] op,
                               input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] az, input logic [31:0] bx,
                               input logic [31:0] by, input logic [31:0] bz,
                               input logic [31:0] sc);
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        while ($urandom_range(1, 100) <= src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        a = '{ax, ay, az};
        b = '{bx, by, bz};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {sc, bz, by, bx, az, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(vector_result(op, a, b, sc));
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic [2:0] op);
        send_vector(op, rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_vector(OP_ADD, 32'h7fffffff, 32'h80000000, 32'd5, 32'd1, 32'hffffffff, 32'd7, 0);
        send_vector(OP_SUB, 32'h80000000, 32'h7fffffff, 32'd5, 32'd1, 32'hffffffff, 32'd9, 0);
        send_vector(OP_SCALE, 32'h00018000, 32'hfffe8000, 32'h7fffffff, 0, 0, 0, 32'h00020000);
        send_vector(OP_SCALE, 32'h00000001, 32'hffffffff, 32'h00000003, 0, 0, 0, 32'h00008000);
        send_vector(OP_MUL, 32'h80000000, 32'h00010000, 32'h12345678,
                    32'h80000000, 32'hffff0000, 32'h00000001, 0);
        send_vector(OP_DOT, 32'h00010000, 32'h00020000, 32'h00030000,
                    32'h00040000, 32'h00050000, 32'h00060000, 0);
        send_vector(OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_vector(OP_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0);
        send_vector(OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
        // zero and unit magnitude pass A through
        send_vector(OP_NORM, 0, 0, 0, 1, 2, 3, 4);
        send_vector(OP_NORM, 32'hffff0000, 0, 0, 0, 0, 0, 0);
        send_vector(OP_NORM, 0, 32'h00010000, 32'h00000010, 0, 0, 0, 0);
        send_vector(OP_NORM, 32'h00000001, 0, 0, 0, 0, 0, 0);
        send_vector(OP_NORM, 32'h00030000, 32'hfffc0000, 0, 0, 0, 0, 0);
        send_vector(OP_NORM, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
        send_vector(3'd7, 32'h7fffffff, 32'h80000000, 1, 2, 3, 4, 5);
        drain();
    endtask

    task automatic test_random_phase(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) send_random(3'($urandom_range(0, 7)));
        src_idle_pct = 0;
        sink_stall_pct = 0;
        drain();
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        for (int i = 0; i < 120; i++) send_random(3'($urandom_range(0, 7)));
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phase(0, 0, 220);
        test_random_phase(51, 0, 220);
        test_random_phase(0, 51, 220);
        test_random_phase(8, 8, 220);
        test_backpressure();
        if (mismatch_count == 0 && !timed_out) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Downstream ready: random stalls, plus one long hold-off.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(1, 100) > sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        vec_result_t got;
        vec_result_t exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1]};
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result transaction %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp x=%h y=%h z=%h dot=%h sat=%b pt=%b,",
                                  " got x=%h y=%h z=%h dot=%h sat=%b pt=%b"},
                                 exp_r.r_x, exp_r.r_y, exp_r.r_z, exp_r.dot_value,
                                 exp_r.saturated, exp_r.passed_through,
                                 got.r_x, got.r_y, got.r_z, got.dot_value,
                                 got.saturated, got.passed_through);
                end
            end
        end
    end

    // Watchdog: count cycles without any transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            timed_out = 1'b1;
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        mismatch_count = 0;
        timed_out = 1'b0;
    end

endmodule
